>>> rtl/blt_pkg.sv
// ----------------------------------------------------------------------------
// blt_pkg
// Types, constants and colour-wheel functions for the bouncing line trail.
// ----------------------------------------------------------------------------
package blt_pkg;

    localparam int COORD_W = 11;
    localparam int SEED_W  = 10;
    localparam int VEL_W   = 5;
    localparam int COLOR_W = 16;
    localparam int LIM_W   = 11;
    localparam int HUE_W   = 7;
    localparam int CFG_W   = 11;
    localparam int IDX_W   = 1;

    // register indexes
    localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [CFG_W-1:0]   LIMIT_RESET = 11'd132;
    localparam logic [LIM_W-1:0]   LIMIT_MIN   = 11'd16;
    localparam logic [LIM_W-1:0]   LIMIT_MAX   = 11'd1024;
    localparam logic [HUE_W-1:0]   HUE_PHASE   = 7'd42;   // a third of the wheel
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hFFFF;
    localparam logic [COLOR_W-1:0] COLOR_ERASE = 16'h0000;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic signed [VEL_W-1:0] vel_t;

    typedef struct packed {
        coord_t y1;
        coord_t x1;
        coord_t y0;
        coord_t x0;
    } line_t;

    // ring store control from the tick stage
    typedef struct packed {
        logic en;
        logic seed_load;
    } ring_ctrl_t;

    function automatic logic [LIM_W-1:0] eff_limit(input logic [CFG_W-1:0] r);
        if (r < LIMIT_MIN) begin
            return LIMIT_MIN;
        end else if (r > LIMIT_MAX) begin
            return LIMIT_MAX;
        end
        return r;
    endfunction

    // quarter wave of round(256*sin), limited to 255
    function automatic logic [7:0] qsine(input logic [5:0] i);
        logic [7:0] v;
        case (i)
            6'd0:  v = 8'd0;
            6'd1:  v = 8'd13;
            6'd2:  v = 8'd25;
            6'd3:  v = 8'd38;
            6'd4:  v = 8'd50;
            6'd5:  v = 8'd62;
            6'd6:  v = 8'd74;
            6'd7:  v = 8'd86;
            6'd8:  v = 8'd98;
            6'd9:  v = 8'd109;
            6'd10: v = 8'd121;
            6'd11: v = 8'd132;
            6'd12: v = 8'd142;
            6'd13: v = 8'd152;
            6'd14: v = 8'd162;
            6'd15: v = 8'd172;
            6'd16: v = 8'd181;
            6'd17: v = 8'd190;
            6'd18: v = 8'd198;
            6'd19: v = 8'd206;
            6'd20: v = 8'd213;
            6'd21: v = 8'd220;
            6'd22: v = 8'd226;
            6'd23: v = 8'd231;
            6'd24: v = 8'd237;
            6'd25: v = 8'd241;
            6'd26: v = 8'd245;
            6'd27: v = 8'd248;
            6'd28: v = 8'd251;
            6'd29: v = 8'd253;
            6'd30: v = 8'd255;
            6'd31: v = 8'd255;
            6'd32: v = 8'd255;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    // sine wheel offset by 256, range 1..511
    function automatic logic [8:0] wheel_off(input logic [HUE_W-1:0] a);
        logic [7:0] s;
        logic       pos;
        if (a <= 7'd32) begin
            s   = qsine(a[5:0]);
            pos = 1'b1;
        end else if (a <= 7'd64) begin
            s   = qsine(6'(7'd64 - a));
            pos = 1'b1;
        end else if (a <= 7'd96) begin
            s   = qsine(6'(a - 7'd64));
            pos = 1'b0;
        end else begin
            s   = qsine(6'(8'd128 - {1'b0, a}));
            pos = 1'b0;
        end
        return pos ? 9'(9'd256 + {1'b0, s}) : 9'(9'd256 - {1'b0, s});
    endfunction

    function automatic logic [COLOR_W-1:0] hue_color(input logic [HUE_W-1:0] h);
        logic [HUE_W-1:0] ga;
        logic [HUE_W-1:0] ba;
        logic [8:0]       r;
        logic [8:0]       g;
        logic [8:0]       b;
        ga = h + HUE_PHASE;
        ba = ga + HUE_PHASE;
        r  = wheel_off(h);
        g  = wheel_off(ga);
        b  = wheel_off(ba);
        return {r[8:4], g[8:3], b[8:4]};
    endfunction

endpackage

>>> rtl/blt_bounce.sv
// ----------------------------------------------------------------------------
// blt_bounce
// Moves one coordinate by its velocity, reflecting at 0 and at the limit.
// ----------------------------------------------------------------------------
module blt_bounce
    import blt_pkg::*;
(
    input  coord_t           coord,
    input  vel_t             vel,
    input  logic [LIM_W-1:0] lim,
    output coord_t           coord_next,
    output vel_t             vel_next
);

    logic signed [12:0] lim_s;
    logic signed [12:0] p0;
    logic signed [12:0] p1;
    logic signed [12:0] p2;
    logic signed [12:0] p3;
    vel_t               v1;

    always_comb begin
        lim_s = $signed({2'b00, lim});
        p0    = $signed({2'b00, coord}) + 13'(vel);
        if (p0 < 0) begin
            p1 = -p0;
            v1 = 5'sd0 - vel;   // wraps, so -16 stays -16
        end else begin
            p1 = p0;
            v1 = vel;
        end
        if (p1 >= lim_s) begin
            p2       = (lim_s <<< 1) - p1;
            vel_next = 5'sd0 - v1;
        end else begin
            p2       = p1;
            vel_next = v1;
        end
        if (p2 < 0) begin
            p3 = '0;
        end else if (p2 > lim_s - 13'sd1) begin
            p3 = lim_s - 13'sd1;
        end else begin
            p3 = p2;
        end
        coord_next = p3[COORD_W-1:0];
    end

endmodule

>>> rtl/blt_ring.sv
// ----------------------------------------------------------------------------
// blt_ring
// Trail ring of line coordinates: one write and one registered read per tick,
// per-slot valid bits for the cleared reset state, and a seed slot override.
// ----------------------------------------------------------------------------
module blt_ring
    import blt_pkg::*;
#(
    parameter int DEPTH = 20,
    parameter int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ring_ctrl_t       ctrl,
    input  logic [PTR_W-1:0] addr,
    input  line_t            wr_line,
    input  line_t            seed_line,
    output line_t            rd_line
);

    line_t            mem [DEPTH];
    line_t            rd_data_reg;
    line_t            fix_reg;
    logic             use_mem_reg;
    logic [DEPTH-1:0] valid_reg;
    logic             seed_pend_reg;
    line_t            seed_reg;
    logic             seed_hit;

    // slot 0 holds the seed line until the trail overwrites it
    assign seed_hit = seed_pend_reg && (addr == '0);

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            rd_data_reg <= mem[addr];
            mem[addr]   <= wr_line;
            fix_reg     <= seed_hit ? seed_reg : '0;
            use_mem_reg <= valid_reg[addr] && !seed_hit;
        end
        if (ctrl.en && ctrl.seed_load) begin
            seed_reg <= seed_line;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            seed_pend_reg <= 1'b0;
        end else if (ctrl.en) begin
            valid_reg[addr] <= 1'b1;
            if (ctrl.seed_load) begin
                seed_pend_reg <= 1'b1;
            end else if (addr == '0) begin
                seed_pend_reg <= 1'b0;
            end
        end
    end

    assign rd_line = use_mem_reg ? rd_data_reg : fix_reg;

endmodule

>>> rtl/bouncing_line_trail.sv
// ----------------------------------------------------------------------------
// bouncing_line_trail
// Bouncing-line animation engine: one tick in, head line and erase line out.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   tvalid/tready      tdata: seeds, tuser: mode
//  m_       out  tvalid/tready      tdata: line, tuser: is_erase, tlast: last
//  cfg_     in   wr_en              index, wdata (screen width / height)
//
// A tick sits in the input register, is worked combinationally and lands in the
// result pair register; the pair is shown as a head word, then an erase word.
// A new tick can wait in the input register while the pair is shown; it is
// worked as the erase word is taken. Head word from the pair, erase from the ring.
// Reset is synchronous; the ring reads as zeros after reset via valid bits.
// Output stalls hold the pair and back up into the input register.
// ----------------------------------------------------------------------------
module bouncing_line_trail
    import blt_pkg::*;
#(
    parameter int RING_DEPTH = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // x0[9:0] y0[19:10] x1[29:20] y1[39:30] vx0[44:40] vy0[49:45]
    // vx1[54:50] vy1[59:55], zero pad
    input  logic [63:0]      s_tdata,
    // mode[0]
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // x0[10:0] y0[21:11] x1[32:22] y1[43:33] color[59:44], zero pad
    output logic [63:0]      m_tdata,
    // is_erase[0]
    output logic             m_tuser,
    output logic             m_tlast,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;

    logic               in_valid_reg;
    logic               in_mode_reg;
    logic [59:0]        in_data_reg;

    logic               started_reg;
    line_t              head_line_reg;
    logic [COLOR_W-1:0] head_color_reg;
    vel_t               vel_reg [4];
    logic [PTR_W-1:0]   tail_reg;
    logic [HUE_W-1:0]   hue_reg;

    logic               pair_valid_reg;
    logic               phase_reg;
    line_t              pair_head_reg;
    logic [COLOR_W-1:0] pair_color_reg;

    logic               advance;
    logic               restart;
    line_t              seed_line;
    line_t              head;
    logic [COLOR_W-1:0] head_color;
    vel_t               vel [4];
    vel_t               vel_next [4];
    logic [HUE_W-1:0]   hue;
    logic [PTR_W-1:0]   tail;
    line_t              moved;
    line_t              erase_line;
    logic [LIM_W-1:0]   wl;
    logic [LIM_W-1:0]   hl;
    ring_ctrl_t         ring_ctrl;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= LIMIT_RESET;
            height_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_wdata;
                REG_SCREEN_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // handshake
    assign advance  = in_valid_reg && (!pair_valid_reg || (phase_reg && m_tready));
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_data_reg <= s_tdata[59:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= (s_tvalid && s_tready) || (in_valid_reg && !advance);
        end
    end

    // tick
    assign restart      = !started_reg || in_mode_reg;
    assign seed_line.x0 = COORD_W'(in_data_reg[9:0]);
    assign seed_line.y0 = COORD_W'(in_data_reg[19:10]);
    assign seed_line.x1 = COORD_W'(in_data_reg[29:20]);
    assign seed_line.y1 = COORD_W'(in_data_reg[39:30]);
    assign wl           = eff_limit(width_reg);
    assign hl           = eff_limit(height_reg);

    always_comb begin
        head       = restart ? seed_line : head_line_reg;
        head_color = restart ? COLOR_WHITE : head_color_reg;
        hue        = restart ? '0 : hue_reg;
        tail       = restart ? LAST_SLOT : tail_reg;
        for (int i = 0; i < 4; i++) begin
            vel[i] = restart ? vel_t'(in_data_reg[40 + 5*i +: 5]) : vel_reg[i];
        end
    end

    blt_bounce u_bx0 (
        .coord(head.x0), .vel(vel[0]), .lim(wl), .coord_next(moved.x0), .vel_next(vel_next[0])
    );
    blt_bounce u_by0 (
        .coord(head.y0), .vel(vel[1]), .lim(hl), .coord_next(moved.y0), .vel_next(vel_next[1])
    );
    blt_bounce u_bx1 (
        .coord(head.x1), .vel(vel[2]), .lim(wl), .coord_next(moved.x1), .vel_next(vel_next[2])
    );
    blt_bounce u_by1 (
        .coord(head.y1), .vel(vel[3]), .lim(hl), .coord_next(moved.y1), .vel_next(vel_next[3])
    );

    always_ff @(posedge aclk) begin
        if (advance) begin
            head_line_reg  <= moved;
            head_color_reg <= hue_color(hue);
            for (int i = 0; i < 4; i++) begin
                vel_reg[i] <= vel_next[i];
            end
            pair_head_reg  <= head;
            pair_color_reg <= head_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            tail_reg    <= '0;
            hue_reg     <= '0;
        end else if (advance) begin
            started_reg <= 1'b1;
            tail_reg    <= (tail == LAST_SLOT) ? '0 : PTR_W'(tail + 1'b1);
            hue_reg     <= hue + 1'b1;
        end
    end

    assign ring_ctrl.en        = advance;
    assign ring_ctrl.seed_load = restart;

    blt_ring #(
        .DEPTH(RING_DEPTH),
        .PTR_W(PTR_W)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ring_ctrl),
        .addr     (tail),
        .wr_line  (moved),
        .seed_line(seed_line),
        .rd_line  (erase_line)
    );

    // result pair: head word then erase word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end else if (pair_valid_reg && m_tready) begin
            if (!phase_reg) begin
                phase_reg <= 1'b1;
            end else begin
                phase_reg      <= 1'b0;
                pair_valid_reg <= advance;
            end
        end else if (advance) begin
            pair_valid_reg <= 1'b1;
            phase_reg      <= 1'b0;
        end
    end

    assign m_tvalid = pair_valid_reg;
    assign m_tuser  = phase_reg;
    assign m_tlast  = phase_reg;
    assign m_tdata  = phase_reg ? {4'b0, COLOR_ERASE, erase_line}
                                : {4'b0, pair_color_reg, pair_head_reg};

endmodule

>>> rtl/blt_checker.sv
// ----------------------------------------------------------------------------
// blt_checker
// Port-level checks on the bouncing line trail result stream.
// ----------------------------------------------------------------------------
module blt_checker
    import blt_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [63:0]      m_tdata,
    input logic             m_tuser,
    input logic             m_tlast
);

    // stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // erase word follows its head word at once
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("erase word missing after head word");

    a_erase_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("erase flag and last disagree");

    a_erase_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata[59:44] == COLOR_ERASE))
        else $error("erase word not black");

endmodule

bind bouncing_line_trail blt_checker u_blt_checker (.*);
